@@ design/bsc_pkg.sv @@
// Package for the barometric sensor compensation block: register indexes,
// constants, stage structs and the shared sign-extension helper. No dependencies.
`default_nettype none
package bsc_pkg;

	localparam int DivW = 32;

	typedef enum logic [1:0] {
		REG_TEMP_COEFFS  = 2'd0,
		REG_PRESS_COEFFS = 2'd1,
		REG_PRESS_EXTRA  = 2'd2,
		REG_OVERSAMPLING = 2'd3
	} reg_idx_t;

	localparam logic [31:0] B6_OFFSET = 32'd4000;
	localparam logic [31:0] P_C1      = 32'd3038;
	localparam logic [31:0] P_C2      = 32'hFFFF_E343; // -7357
	localparam logic [31:0] P_C3      = 32'd3791;
	localparam logic [31:0] B4_BIAS   = 32'd32768;
	localparam logic [31:0] B7_SCALE  = 32'd50000;

	// one item travelling through a divider
	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] quo;
		logic [31:0] dvs;
	} div_st_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
		asr32 = 32'($signed(x) >>> n);
	endfunction

	// one restoring division step
	function automatic div_st_t div_step(input div_st_t s);
		logic [32:0] trial;
		div_st_t r;
		trial = {s.rem, s.quo[31]} - {1'b0, s.dvs};
		r.dvs = s.dvs;
		if (!trial[32]) begin
			r.rem = trial[31:0];
			r.quo = {s.quo[30:0], 1'b1};
		end else begin
			r.rem = {s.rem[30:0], s.quo[31]};
			r.quo = {s.quo[30:0], 1'b0};
		end
		div_step = r;
	endfunction

endpackage
`default_nettype wire

@@ design/bsc_udiv.sv @@
// Pipelined 32-bit unsigned divider, four quotient bits per stage, eight stages.
// Carries a side payload alongside. Depends on bsc_pkg.
`default_nettype none
module bsc_udiv (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [31:0]         dividend,
	input  wire logic [31:0]         divisor,
	input  wire logic [255:0]        side_in,
	output logic                     out_valid,
	output logic [31:0]              quotient,
	output logic [255:0]             side_out
);
	import bsc_pkg::*;

	localparam int Stages = 8;
	localparam int BitsPerStage = DivW / Stages;

	div_st_t      st_s   [Stages+1];
	logic [255:0] side_s [Stages+1];
	logic         vld_s  [Stages+1];

	assign st_s[0]   = '{rem: 32'd0, quo: dividend, dvs: divisor};
	assign side_s[0] = side_in;
	assign vld_s[0]  = in_valid;

	for (genvar g = 0; g < Stages; g++) begin : g_stage
		div_st_t nxt;
		always_comb begin
			nxt = st_s[g];
			for (int k = 0; k < BitsPerStage; k++) begin
				nxt = div_step(nxt);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end
		always_ff @(posedge clk) begin
			st_s[g+1]   <= nxt;
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_valid = vld_s[Stages];
	assign quotient  = st_s[Stages].quo;
	assign side_out  = side_s[Stages];

endmodule
`default_nettype wire

@@ design/bsc_temp.sv @@
// Temperature front end: X1, mc<<11 / (X1+md) via the pipelined divider, B5, T.
// Depends on bsc_pkg and bsc_udiv.
`default_nettype none
module bsc_temp (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [15:0] adc_temp,
	input  wire logic [18:0] adc_press,
	input  wire logic [63:0] temp_coeffs,
	output logic             out_valid,
	output logic [31:0]      b5,
	output logic [15:0]      temp,
	output logic [18:0]      up,
	output logic             err
);
	import bsc_pkg::*;

	logic        vld_s1;
	logic [31:0] x1_s1, md_s1, mc_s1;
	logic [18:0] up_s1;
	logic [31:0] den_s2, num_s2, x1_s2;
	logic [18:0] up_s2;
	logic        vld_s2;
	logic [31:0] mag_n, mag_d;
	logic [255:0] side_in, side_out;
	logic [31:0] q;
	logic        dv;
	logic [31:0] b5_c, t_sum, t_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		x1_s1 <= asr32(({16'd0, adc_temp} - {16'd0, temp_coeffs[31:16]})
			* {16'd0, temp_coeffs[15:0]}, 5'd15);
		md_s1 <= sx16(temp_coeffs[63:48]);
		mc_s1 <= sx16(temp_coeffs[47:32]) << 11;
		up_s1 <= adc_press;
		den_s2 <= x1_s1 + md_s1;
		num_s2 <= mc_s1;
		x1_s2  <= x1_s1;
		up_s2  <= up_s1;
	end

	assign mag_n = num_s2[31] ? 32'd0 - num_s2 : num_s2;
	assign mag_d = den_s2[31] ? 32'd0 - den_s2 : den_s2;
	assign side_in = {165'd0, up_s2, x1_s2, num_s2[31] ^ den_s2[31], den_s2 == 32'd0,
		6'd0, 32'd0};

	bsc_udiv u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s2),
		.dividend(mag_n), .divisor(mag_d), .side_in(side_in),
		.out_valid(dv), .quotient(q), .side_out(side_out)
	);

	always_comb begin
		b5_c  = side_out[71:40] + (side_out[39] ? 32'd0 - q : q);
		t_sum = b5_c + 32'd8;
		t_mag = t_sum[31] ? 32'd0 - t_sum : t_sum;
		t_mag = t_mag >> 4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= dv;
		end
	end

	always_ff @(posedge clk) begin
		b5   <= b5_c;
		temp <= t_sum[31] ? 16'(32'd0 - t_mag) : t_mag[15:0];
		up   <= side_out[90:72];
		err  <= side_out[38];
	end

endmodule
`default_nettype wire

@@ design/bsc_press.sv @@
// Pressure back end: B6, B3, B4, B7, the B7/B4 division and final correction.
// Depends on bsc_pkg and bsc_udiv.
`default_nettype none
module bsc_press (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [31:0] b5,
	input  wire logic [15:0] temp,
	input  wire logic [18:0] up,
	input  wire logic        err_in,
	input  wire logic [63:0] press_coeffs,
	input  wire logic [31:0] press_extra,
	input  wire logic [1:0]  oss,
	output logic             out_valid,
	output logic [15:0]      temperature_tenths,
	output logic [31:0]      pressure_pa,
	output logic             div_error
);
	import bsc_pkg::*;

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic [31:0] b6_s1, sq_s2, x1b_s2, x2a_s2;
	logic [31:0] x1a_s3, x2a_s3, x1b_s3, x2b_s3;
	logic [31:0] b3_s4, b4_s4, b7_s5, b4_s5;
	logic [15:0] t_s1, t_s2, t_s3, t_s4, t_s5, t_s6, t_s7;
	logic [18:0] u_s1, u_s2, u_s3, u_s4;
	logic        e_s1, e_s2, e_s3, e_s4, e_s5, e_s6, e_s7;
	logic [31:0] x3a, x3b, b3_c, b4_c;
	logic [255:0] side_in, side_out;
	logic [31:0] q, p_s6, sq_s7, px_s7, py_s7;
	logic        dv;

	always_comb begin
		x3a  = asr32(x1a_s3, 5'd11) + asr32(x2a_s3, 5'd11);
		b3_c = (((sx16(press_coeffs[15:0]) << 2) + x3a) << oss) + 32'd2;
		// divide by 4 toward zero
		b3_c = asr32(b3_c[31] ? b3_c + 32'd3 : b3_c, 5'd2);
		x3b  = asr32(asr32(x1b_s3, 5'd13) + asr32(x2b_s3, 5'd16) + 32'd2, 5'd2);
		b4_c = ({16'd0, press_coeffs[63:48]} * (x3b + B4_BIAS)) >> 15;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5} <= '0;
			{vld_s6, vld_s7, out_valid} <= '0;
		end else begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5} <= {in_valid, vld_s1, vld_s2, vld_s3, vld_s4};
			{vld_s6, vld_s7, out_valid} <= {dv, vld_s6, vld_s7};
		end
	end

	always_ff @(posedge clk) begin
		b6_s1 <= b5 - B6_OFFSET; t_s1 <= temp; u_s1 <= up; e_s1 <= err_in;
		sq_s2  <= asr32(b6_s1 * b6_s1, 5'd12);
		x1b_s2 <= sx16(press_coeffs[47:32]) * b6_s1;
		x2a_s2 <= sx16(press_coeffs[31:16]) * b6_s1;
		t_s2 <= t_s1; u_s2 <= u_s1; e_s2 <= e_s1;
		x1a_s3 <= sx16(press_extra[31:16]) * sq_s2;
		x2b_s3 <= sx16(press_extra[15:0]) * sq_s2;
		x2a_s3 <= x2a_s2; x1b_s3 <= x1b_s2;
		t_s3 <= t_s2; u_s3 <= u_s2; e_s3 <= e_s2;
		b3_s4 <= b3_c; b4_s4 <= b4_c; t_s4 <= t_s3; u_s4 <= u_s3; e_s4 <= e_s3;
		b7_s5 <= ({13'd0, u_s4} - b3_s4) * (B7_SCALE >> oss);
		b4_s5 <= b4_s4; t_s5 <= t_s4; e_s5 <= e_s4 | (b4_s4 == 32'd0);
	end

	assign side_in = {206'd0, t_s5, e_s5, b7_s5[31], 32'd0};

	bsc_udiv u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s5),
		.dividend(b7_s5[31] ? b7_s5 : b7_s5 << 1), .divisor(b4_s5),
		.side_in(side_in), .out_valid(dv), .quotient(q), .side_out(side_out)
	);

	always_ff @(posedge clk) begin
		p_s6 <= side_out[32] ? q << 1 : q;
		t_s6 <= side_out[49:34]; e_s6 <= side_out[33];
		sq_s7 <= asr32(p_s6, 5'd8) * asr32(p_s6, 5'd8);
		px_s7 <= asr32(P_C2 * p_s6, 5'd16);
		py_s7 <= p_s6; t_s7 <= t_s6; e_s7 <= e_s6;
		pressure_pa <= e_s7 ? 32'd0 : py_s7 + asr32(asr32(sq_s7 * P_C1, 5'd16)
			+ px_s7 + P_C3, 5'd4);
		temperature_tenths <= e_s7 ? 16'd0 : t_s7;
		div_error <= e_s7;
	end

endmodule
`default_nettype wire

@@ design/baro_sensor_compensation.sv @@
// Barometric sensor compensation: one item (raw temperature, raw pressure) per
// cycle, fully pipelined through two 8-stage dividers; the result strobe follows
// start through 2 temperature stages, 8 divider stages, 1 temperature output
// stage, 5 pressure stages, 8 divider stages and 3 correction and output stages.
// busy stays low; the receiver cannot stall.
// Depends on bsc_pkg, bsc_temp, bsc_press.
`default_nettype none
module baro_sensor_compensation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] adc_temp,
	input  wire logic [18:0] adc_press,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	output logic             done,
	output logic [15:0]      temperature_tenths,
	output logic [31:0]      pressure_pa,
	output logic             div_error
);
	import bsc_pkg::*;

	logic [63:0] temp_coeffs_q, press_coeffs_q;
	logic [31:0] press_extra_q;
	logic [1:0]  oss_q;
	logic        tv, te;
	logic [31:0] b5;
	logic [15:0] tt;
	logic [18:0] up;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0; press_coeffs_q <= '0; press_extra_q <= '0; oss_q <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TEMP_COEFFS:  temp_coeffs_q  <= cfg_data;
				REG_PRESS_COEFFS: press_coeffs_q <= cfg_data;
				REG_PRESS_EXTRA:  press_extra_q  <= cfg_data[31:0];
				REG_OVERSAMPLING: oss_q          <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	bsc_temp u_temp (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.adc_temp(adc_temp), .adc_press(adc_press),
		.temp_coeffs(temp_coeffs_q), .out_valid(tv), .b5(b5), .temp(tt),
		.up(up), .err(te)
	);

	bsc_press u_press (
		.clk(clk), .arst_n(arst_n), .in_valid(tv), .b5(b5), .temp(tt), .up(up),
		.err_in(te), .press_coeffs(press_coeffs_q), .press_extra(press_extra_q),
		.oss(oss_q), .out_valid(done), .temperature_tenths(temperature_tenths),
		.pressure_pa(pressure_pa), .div_error(div_error)
	);

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy asserted");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && div_error |-> pressure_pa == 32'd0 && temperature_tenths == 16'd0)
		else $error("error result not zero");
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("cfg not ready");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking bench for baro_sensor_compensation: drives raw readings, predicts the
// compensated temperature and pressure per item and compares them on each done strobe.
// Depends on bsc_pkg and the block's RTL.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bsc_pkg::*;

	typedef struct {
		logic [15:0] temp;
		logic [31:0] press;
		logic        err;
	} reading_t;

	logic clk = 1'b0, arst_n = 1'b0, start = 1'b0, cfg_valid = 1'b0;
	logic [15:0] adc_temp = '0;
	logic [18:0] adc_press = '0;
	logic [1:0]  cfg_index = REG_TEMP_COEFFS;
	logic [63:0] cfg_data = '0;
	logic busy, cfg_ready, done, div_error;
	logic [15:0] temperature_tenths;
	logic [31:0] pressure_pa;

	logic [63:0] tcoef, pcoef;
	logic [31:0] pextra;
	logic [1:0]  oss;
	reading_t    pending[$];
	int unsigned errors, sent, checked, errs_seen, cycles;
	int unsigned burst_len;

	baro_sensor_compensation dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [31:0] div_signed(logic [31:0] a, logic [31:0] b);
		logic [31:0] ua, ub, q;
		ua = a[31] ? -a : a;
		ub = b[31] ? -b : b;
		q = ua / ub;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic logic [31:0] sra(logic [31:0] x, int n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic reading_t compensate(logic [15:0] ut16, logic [18:0] up19);
		reading_t r;
		logic [31:0] ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2, ut, up;
		logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
		ac5 = {16'd0, tcoef[15:0]};
		ac6 = {16'd0, tcoef[31:16]};
		mc = {{16{tcoef[47]}}, tcoef[47:32]};
		md = {{16{tcoef[63]}}, tcoef[63:48]};
		ac1 = {{16{pcoef[15]}}, pcoef[15:0]};
		ac2 = {{16{pcoef[31]}}, pcoef[31:16]};
		ac3 = {{16{pcoef[47]}}, pcoef[47:32]};
		ac4 = {16'd0, pcoef[63:48]};
		b1 = {{16{pextra[15]}}, pextra[15:0]};
		b2 = {{16{pextra[31]}}, pextra[31:16]};
		ut = {16'd0, ut16};
		up = {13'd0, up19};
		r = '{temp: '0, press: '0, err: 1'b0};
		x1 = sra((ut - ac6) * ac5, 15);
		den = x1 + md;
		if (den == 0) begin
			r.err = 1'b1;
			return r;
		end
		x2 = div_signed(mc << 11, den);
		b5 = x1 + x2;
		r.temp = 16'(div_signed(b5 + 32'd8, 32'd16));
		b6 = b5 - 32'd4000;
		sq = sra(b6 * b6, 12);
		x3 = sra(b2 * sq, 11) + sra(ac2 * b6, 11);
		b3 = div_signed(((ac1 * 4 + x3) << oss) + 32'd2, 32'd4);
		x3 = sra(sra(ac3 * b6, 13) + sra(b1 * sq, 16) + 32'd2, 2);
		b4 = (ac4 * (x3 + 32'd32768)) >> 15;
		if (b4 == 0) begin
			r = '{temp: '0, press: '0, err: 1'b1};
			return r;
		end
		b7 = (up - b3) * (32'd50000 >> oss);
		p = b7[31] ? (b7 / b4) * 2 : (b7 * 2) / b4;
		x1 = sra(p, 8);
		x1 = x1 * x1;
		x1 = sra(x1 * 32'd3038, 16);
		x2 = sra(32'hFFFF_E343 * p, 16);
		r.press = p + sra(x1 + x2 + 32'd3791, 4);
		return r;
	endfunction

	// compare each strobed result with the oldest prediction
	always @(posedge clk) begin
		reading_t exp_r;
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				$error("result with no item pending");
				errors++;
			end else begin
				exp_r = pending.pop_front();
				checked++;
				if (div_error) errs_seen++;
				if (temperature_tenths !== exp_r.temp) begin
					$error("temperature_tenths exp %0h got %0h", exp_r.temp, temperature_tenths);
					errors++;
				end
				if (pressure_pa !== exp_r.press) begin
					$error("pressure_pa exp %0h got %0h", exp_r.press, pressure_pa);
					errors++;
				end
				if (div_error !== exp_r.err) begin
					$error("div_error exp %0b got %0b", exp_r.err, div_error);
					errors++;
				end
			end
		end
	end

	task automatic send_item(logic [15:0] ut, logic [18:0] up);
		int unsigned gap;
		// random gap between bursts
		if (burst_len == 0) begin
			burst_len = $urandom_range(1, 20);
			gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_len--;
		start <= 1'b1;
		adc_temp <= ut;
		adc_press <= up;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending.push_back(compensate(ut, up));
		sent++;
	endtask

	task automatic write_reg(reg_idx_t idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_TEMP_COEFFS:  tcoef = val;
			REG_PRESS_COEFFS: pcoef = val;
			REG_PRESS_EXTRA:  pextra = val[31:0];
			REG_OVERSAMPLING: oss = val[1:0];
		endcase
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic load_coeffs(logic [63:0] t, logic [63:0] p, logic [31:0] e, logic [1:0] o);
		write_reg(REG_TEMP_COEFFS, t);
		write_reg(REG_PRESS_COEFFS, p);
		write_reg(REG_PRESS_EXTRA, {32'd0, e});
		write_reg(REG_OVERSAMPLING, {62'd0, o});
		cfg_valid <= 1'b0;
	endtask

	// typical calibration set, nearby values
	function automatic logic [63:0] typ_temp();
		return {16'(2868 + $urandom_range(0, 200) - 100), 16'(-11786 + $urandom_range(0, 400)),
			16'(23153 + $urandom_range(0, 2000) - 1000), 16'(32757 - $urandom_range(0, 3000))};
	endfunction

	function automatic logic [63:0] typ_press();
		return {16'(32741 + $urandom_range(0, 1000) - 500), 16'(-14383 + $urandom_range(0, 200)),
			16'(-72 + $urandom_range(0, 20)), 16'(408 + $urandom_range(0, 100) - 50)};
	endfunction

	task automatic test_reset_defaults();
		// all coefficients zero: md is zero and x1 is zero, so a zero divisor
		send_item(16'd0, 19'd0);
		send_item(16'hFFFF, 19'h7FFFF);
		drain();
	endtask

	task automatic test_directed();
		load_coeffs(64'h0B44_5F32_8F7A_6D8B, 64'h809E_FFB8_C7D1_1A98, 32'h00_9D_3F_0F >> 4, 2'd0);
		send_item(16'd27898, 19'd23843);
		send_item(16'd0, 19'd0);
		send_item(16'hFFFF, 19'h7FFFF);
		send_item(16'h8000, 19'h40000);
		drain();
		// extremes of every register
		load_coeffs('1, '1, '1, 2'd3);
		send_item(16'd0, 19'd0);
		send_item(16'hFFFF, 19'h7FFFF);
		drain();
		// ac5 = 0 and md = 1 give a temperature divisor of one; ac4 = 0 gives zero b4
		load_coeffs({16'h0001, 16'h8000, 16'h0001, 16'h0000}, 64'h0000_1234_5678_9ABC, 32'h0, 2'd1);
		send_item(16'd0, 19'd5);
		send_item(16'd1, 19'd5);
		drain();
		load_coeffs({16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF}, 64'h8000_8000_8000_7FFF,
			32'h7FFF_8000, 2'd2);
		send_item(16'd0, 19'd0);
		send_item(16'hFFFF, 19'h7FFFF);
		send_item(16'h1234, 19'h2AAAA);
		drain();
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 12; phase++) begin
			if (phase % 3 == 2)
				load_coeffs({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 2'($urandom));
			else
				load_coeffs(typ_temp(), typ_press(), {16'(-7 + $urandom_range(0, 14)),
					16'(6190 + $urandom_range(0, 200))}, 2'($urandom));
			for (int i = 0; i < 100; i++) begin
				if ($urandom_range(0, 3) == 0)
					send_item(16'($urandom), 19'($urandom));
				else
					send_item(16'($urandom_range(20000, 35000)),
						19'($urandom_range(20000, 50000) << oss));
			end
			drain();
		end
	endtask

	initial begin
		tcoef = '0;
		pcoef = '0;
		pextra = '0;
		oss = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_random();
		$display("Sent %0d items under %0d settings; %0d results checked, %0d divide errors.",
			sent, 17, checked, errs_seen);
		if (errors == 0 && pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire

@@ baro_sensor_compensation.f @@
design/bsc_pkg.sv
design/bsc_udiv.sv
design/bsc_temp.sv
design/bsc_press.sv
design/baro_sensor_compensation.sv
test/tb_top.sv
